// ----- rtl/mrtu_pkg.sv -----
// Shared types, codes and the CRC-16/MODBUS byte update for the RTU receiver.
package mrtu_pkg;

    localparam int MAX_FRAME_DEF = 256;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [1:0] OP_ARM  = 2'd0;
    localparam logic [1:0] OP_BYTE = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [1:0] REG_FRAME_GAP = 2'd0;
    localparam logic [1:0] REG_GUARD     = 2'd1;
    localparam logic [1:0] REG_TIMEOUT   = 2'd2;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [2:0] ST_GOOD      = 3'd0;
    localparam logic [2:0] ST_CRC_ERR   = 3'd1;
    localparam logic [2:0] ST_NO_RESP   = 3'd2;
    localparam logic [2:0] ST_TOO_SHORT = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;

    localparam logic [19:0] FRAME_GAP_RST = 20'd1562;
    localparam logic [19:0] GUARD_RST     = 20'd3645;
    localparam logic [23:0] TIMEOUT_RST   = 24'd100000;
    localparam logic [23:0] SILENCE_MAX   = 24'hFFFFFF;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] rx_byte;
    } cmd_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [2:0] status;
        logic [7:0] frame_address;
        logic [7:0] payload_length;
    } rsp_t;

    typedef enum logic [1:0] {
        ACT_ARM  = 2'd0,
        ACT_BYTE = 2'd1,
        ACT_TICK = 2'd2
    } act_e;

    typedef struct packed {
        act_e       act;
        logic [7:0] data;
    } act_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  index;
        logic [23:0] data;
    } cfg_wr_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ----- rtl/mrtu_fifo.sv -----
// Small register queue used between the front, the back and the result port.
module mrtu_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_pop  = pop && !empty;
    assign do_push = push && (!full || do_pop);
    assign rdata   = slot_reg[head_reg];

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (do_pop)
        begin
            head_next = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (do_push)
        begin
            tail_next = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[tail_reg] <= wdata;
    end

endmodule

// ----- rtl/mrtu_front.sv -----
// Front end: takes input items, classifies the opcode and queues actions for the back end.
module mrtu_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mrtu_pkg::cmd_t cmd,
    output logic          full,
    input  logic          act_pop,
    output mrtu_pkg::act_t act,
    output logic          act_valid
);
    import mrtu_pkg::*;

    act_t act_in;
    logic keep;
    logic act_empty;
    logic q_full;

    always_comb
    begin
        act_in.data = cmd.rx_byte;
        act_in.act  = ACT_TICK;
        keep        = 1'b1;
        case (cmd.opcode)
            OP_ARM:  act_in.act = ACT_ARM;
            OP_BYTE: act_in.act = ACT_BYTE;
            OP_TICK: act_in.act = ACT_TICK;
            default: keep = 1'b0;
        endcase
    end

    assign full = q_full;

    mrtu_fifo #(
        .WIDTH ($bits(act_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_act_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push && !q_full && keep),
        .wdata (act_in),
        .pop   (act_pop),
        .rdata (act),
        .full  (q_full),
        .empty (act_empty)
    );

    assign act_valid = !act_empty;

endmodule

// ----- rtl/mrtu_back.sv -----
// Back end: frame state machine, silence timing, CRC check and payload delay line.
module mrtu_back #(
    parameter int MAX_FRAME = mrtu_pkg::MAX_FRAME_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  mrtu_pkg::cfg_wr_t cfg_wr,
    input  logic             act_valid,
    input  mrtu_pkg::act_t   act,
    input  logic             room,
    output logic             act_pop,
    output logic             res_valid,
    output mrtu_pkg::rsp_t   res
);
    import mrtu_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME + 1);

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_WAIT  = 4'b0010,
        PH_RECV  = 4'b0100,
        PH_GUARD = 4'b1000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [23:0] silence_reg, silence_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  delay0_reg, delay0_next;
    logic [7:0]  delay1_reg, delay1_next;
    logic [7:0]  addr_reg, addr_next;
    logic        ovf_reg, ovf_next;
    logic [19:0] gap_reg;
    logic [19:0] guard_reg;
    logic [23:0] timeout_reg;

    logic        exec;
    logic [23:0] sil_inc;
    logic [CNT_W-1:0] diff;
    logic [7:0]  len;
    logic        short_frame;

    assign exec    = act_valid && room;
    assign act_pop = exec;
    assign sil_inc = (silence_reg == SILENCE_MAX) ? silence_reg : silence_reg + 24'd1;
    assign short_frame = (count_reg < CNT_W'(3));
    assign diff    = count_reg - CNT_W'(3);
    assign len     = short_frame ? 8'd0 : ((diff > CNT_W'(255)) ? 8'hFF : 8'(diff));

    always_comb
    begin
        phase_next   = phase_reg;
        silence_next = silence_reg;
        count_next   = count_reg;
        crc_next     = crc_reg;
        delay0_next  = delay0_reg;
        delay1_next  = delay1_reg;
        addr_next    = addr_reg;
        ovf_next     = ovf_reg;
        res_valid    = 1'b0;
        res          = '0;
        if (exec)
        begin
            case (act.act)
                ACT_ARM:
                begin
                    phase_next   = PH_WAIT;
                    silence_next = '0;
                    count_next   = '0;
                    crc_next     = CRC_INIT;
                    delay0_next  = '0;
                    delay1_next  = '0;
                    addr_next    = '0;
                    ovf_next     = 1'b0;
                end
                ACT_BYTE:
                begin
                    if (phase_reg == PH_WAIT)
                    begin
                        addr_next    = act.data;
                        crc_next     = crc_feed(crc_reg, act.data);
                        count_next   = CNT_W'(1);
                        silence_next = '0;
                        phase_next   = PH_RECV;
                    end
                    else if (phase_reg == PH_RECV)
                    begin
                        silence_next = '0;
                        if (count_reg >= CNT_W'(MAX_FRAME))
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            if (!short_frame)
                            begin
                                crc_next            = crc_feed(crc_reg, delay1_reg);
                                res_valid           = 1'b1;
                                res.kind            = KIND_DATA;
                                res.data_byte       = delay1_reg;
                                res.status          = ST_GOOD;
                                res.frame_address   = addr_reg;
                                res.payload_length  = 8'd0;
                            end
                            delay1_next = delay0_reg;
                            delay0_next = act.data;
                            count_next  = count_reg + 1'b1;
                        end
                    end
                end
                ACT_TICK:
                begin
                    if (phase_reg == PH_WAIT)
                    begin
                        silence_next = sil_inc;
                        if (sil_inc >= timeout_reg)
                        begin
                            phase_next        = PH_IDLE;
                            res_valid         = 1'b1;
                            res.kind          = KIND_STATUS;
                            res.status        = ST_NO_RESP;
                        end
                    end
                    else if (phase_reg == PH_RECV)
                    begin
                        silence_next = sil_inc;
                        if (sil_inc > {4'd0, gap_reg})
                        begin
                            res_valid          = 1'b1;
                            res.kind           = KIND_STATUS;
                            res.frame_address  = addr_reg;
                            res.payload_length = len;
                            if (ovf_reg)
                                res.status = ST_OVERFLOW;
                            else if (short_frame)
                                res.status = ST_TOO_SHORT;
                            else if (delay1_reg == crc_reg[7:0] && delay0_reg == crc_reg[15:8])
                                res.status = ST_GOOD;
                            else
                                res.status = ST_CRC_ERR;
                            phase_next = (sil_inc >= {4'd0, guard_reg}) ? PH_IDLE : PH_GUARD;
                        end
                    end
                    else if (phase_reg == PH_GUARD)
                    begin
                        silence_next = sil_inc;
                        if (sil_inc >= {4'd0, guard_reg})
                            phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            silence_reg <= '0;
            count_reg   <= '0;
            crc_reg     <= CRC_INIT;
            delay0_reg  <= '0;
            delay1_reg  <= '0;
            addr_reg    <= '0;
            ovf_reg     <= 1'b0;
            gap_reg     <= FRAME_GAP_RST;
            guard_reg   <= GUARD_RST;
            timeout_reg <= TIMEOUT_RST;
        end
        else
        begin
            phase_reg   <= phase_next;
            silence_reg <= silence_next;
            count_reg   <= count_next;
            crc_reg     <= crc_next;
            delay0_reg  <= delay0_next;
            delay1_reg  <= delay1_next;
            addr_reg    <= addr_next;
            ovf_reg     <= ovf_next;
            if (cfg_wr.valid)
            begin
                case (cfg_wr.index)
                    REG_FRAME_GAP: gap_reg     <= cfg_wr.data[19:0];
                    REG_GUARD:     guard_reg   <= cfg_wr.data[19:0];
                    REG_TIMEOUT:   timeout_reg <= cfg_wr.data;
                    default:       gap_reg     <= gap_reg;
                endcase
            end
        end
    end

endmodule

// ----- rtl/modbus_rtu_frame_receiver_core.sv -----
// Modbus RTU response receiver: front classifier, action queue, frame engine, result queue.
// An accepted item is registered in the action queue and its result in the result queue.
// Throughput: one item per cycle unless full; one queued action per cycle unless stalled.
// The engine stalls only while the two-entry result queue is full and not being popped.
// Reset: queues empty, phase idle, CRC all ones, registers return to their defaults.
module modbus_rtu_frame_receiver_core #(
    parameter int MAX_FRAME = mrtu_pkg::MAX_FRAME_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mrtu_pkg::cmd_t cmd,
    output logic           full,
    output logic           empty,
    input  logic           pop,
    output mrtu_pkg::rsp_t rsp,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [1:0]     cfg_index,
    input  logic [23:0]    cfg_data
);
    import mrtu_pkg::*;

    act_t    act;
    logic    act_valid;
    logic    act_pop;
    logic    res_valid;
    rsp_t    res;
    logic    out_full;
    logic    room;
    cfg_wr_t cfg_wr;

    assign cfg_ready     = 1'b1;
    assign cfg_wr.valid  = cfg_valid;
    assign cfg_wr.index  = cfg_index;
    assign cfg_wr.data   = cfg_data;
    assign room          = !out_full || (pop && !empty);

    mrtu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .cmd       (cmd),
        .full      (full),
        .act_pop   (act_pop),
        .act       (act),
        .act_valid (act_valid)
    );

    mrtu_back #(
        .MAX_FRAME (MAX_FRAME)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_wr),
        .act_valid (act_valid),
        .act       (act),
        .room      (room),
        .act_pop   (act_pop),
        .res_valid (res_valid),
        .res       (res)
    );

    mrtu_fifo #(
        .WIDTH ($bits(rsp_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_rsp_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_valid && act_pop),
        .wdata (res),
        .pop   (pop),
        .rdata (rsp),
        .full  (out_full),
        .empty (empty)
    );

    a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && act_pop) |-> (!out_full || (pop && !empty)))
        else $error("result written into a full queue");

    a_data_item_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && rsp.kind == KIND_DATA)
            |-> (rsp.status == ST_GOOD && rsp.payload_length == 8'd0))
        else $error("payload item carries status fields");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && rsp.kind == KIND_STATUS)
            |-> (rsp.status <= ST_OVERFLOW && rsp.data_byte == 8'd0))
        else $error("status item out of range");

    a_no_response_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && rsp.status == ST_NO_RESP)
            |-> (rsp.frame_address == 8'd0 && rsp.payload_length == 8'd0))
        else $error("no-response status carries frame fields");

endmodule

// ----- bench/modbus_rtu_frame_receiver_core_tb.sv -----
// Self-checking bench for the Modbus RTU frame receiver core: planned frames, prediction.
module modbus_rtu_frame_receiver_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mrtu_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_WAIT  = 2'd1,
        PH_RECV  = 2'd2,
        PH_GUARD = 2'd3
    } rx_phase_e;

    localparam logic [1:0] OP_NOP       = 2'd3;
    localparam int         SETTLE_TICKS = 8;
    localparam int         HOLD_CYCLES  = 300;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        push      = 1'b0;
    cmd_t        cmd       = '0;
    logic        full;
    logic        empty;
    logic        pop       = 1'b0;
    rsp_t        rsp;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [23:0] cfg_data  = '0;

    modbus_rtu_frame_receiver_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .cmd       (cmd),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cmd_t cmd_plan[$];
    rsp_t due_results[$];
    int   planned;
    int   fault_count;
    int   send_idle_pct;
    int   recv_stall_pct;
    bit   hold_go;
    bit   holding;

    logic [19:0] gap_ticks;
    logic [19:0] guard_ticks;
    logic [23:0] resp_ticks;

    rx_phase_e   ph;
    logic [23:0] quiet_ticks;
    int          frame_bytes;
    logic [15:0] frame_crc;
    logic [7:0]  lag [2];
    logic [7:0]  station;
    bit          overrun;

    always #5 clk = ~clk;

    function automatic logic [15:0] crc16_modbus(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        lsb;
        c = {crc[15:8], crc[7:0] ^ b};
        for (int i = 0; i < 8; i++) begin
            lsb = c[0];
            c = {1'b0, c[15:1]};
            if (lsb)
                c = c ^ 16'hA001;
        end
        return c;
    endfunction

    function automatic string fmt_rsp(input rsp_t r);
        return $sformatf("kind=%0d data=%02h st=%0d addr=%02h len=%0d",
                         r.kind, r.data_byte, r.status, r.frame_address, r.payload_length);
    endfunction

    task automatic clear_frame();
        quiet_ticks = '0;
        frame_bytes = 0;
        frame_crc   = 16'hFFFF;
        lag[0]      = '0;
        lag[1]      = '0;
        station     = '0;
        overrun     = 1'b0;
    endtask

    task automatic frame_rx_step(input cmd_t c);
        rsp_t r;
        int   len;
        r = '0;
        case (c.opcode)
            OP_ARM: begin
                clear_frame();
                ph = PH_WAIT;
            end
            OP_BYTE: begin
                if (ph == PH_WAIT) begin
                    station     = c.rx_byte;
                    frame_crc   = crc16_modbus(frame_crc, c.rx_byte);
                    frame_bytes = 1;
                    quiet_ticks = '0;
                    ph          = PH_RECV;
                end else if (ph == PH_RECV) begin
                    quiet_ticks = '0;
                    if (frame_bytes >= MAX_FRAME_DEF) begin
                        overrun = 1'b1;
                    end else begin
                        if (frame_bytes >= 3) begin
                            frame_crc       = crc16_modbus(frame_crc, lag[1]);
                            r.kind          = KIND_DATA;
                            r.data_byte     = lag[1];
                            r.status        = ST_GOOD;
                            r.frame_address = station;
                            due_results.push_back(r);
                        end
                        lag[1] = lag[0];
                        lag[0] = c.rx_byte;
                        frame_bytes++;
                    end
                end
            end
            OP_TICK: begin
                if (ph != PH_IDLE && quiet_ticks != SILENCE_MAX)
                    quiet_ticks++;
                if (ph == PH_WAIT) begin
                    if (quiet_ticks >= resp_ticks) begin
                        ph       = PH_IDLE;
                        r.kind   = KIND_STATUS;
                        r.status = ST_NO_RESP;
                        due_results.push_back(r);
                    end
                end else if (ph == PH_RECV) begin
                    if (quiet_ticks > gap_ticks) begin
                        len = 0;
                        if (frame_bytes >= 3)
                            len = (frame_bytes - 3 > 255) ? 255 : frame_bytes - 3;
                        if (overrun)
                            r.status = ST_OVERFLOW;
                        else if (frame_bytes < 3)
                            r.status = ST_TOO_SHORT;
                        else if (lag[1] == frame_crc[7:0] && lag[0] == frame_crc[15:8])
                            r.status = ST_GOOD;
                        else
                            r.status = ST_CRC_ERR;
                        r.kind           = KIND_STATUS;
                        r.frame_address  = station;
                        r.payload_length = len[7:0];
                        due_results.push_back(r);
                        ph = (quiet_ticks >= guard_ticks) ? PH_IDLE : PH_GUARD;
                    end
                end else if (ph == PH_GUARD) begin
                    if (quiet_ticks >= guard_ticks)
                        ph = PH_IDLE;
                end
            end
            default: ;
        endcase
    endtask

    task automatic note_fault(input string what, input rsp_t want, input rsp_t got);
        fault_count++;
        if (fault_count <= 10)
            $display("%t %s: exp %s, got %s", $realtime, what, fmt_rsp(want), fmt_rsp(got));
    endtask

    always @(negedge clk) begin
        if (!rst_n) begin
            push <= 1'b0;
        end else if (cmd_plan.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            push <= 1'b1;
            cmd  <= cmd_plan[0];
        end else begin
            push <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if (rst_n && push && !full) begin
            frame_rx_step(cmd);
            void'(cmd_plan.pop_front());
        end
    end

    always @(negedge clk) begin
        if (!rst_n)
            pop <= 1'b0;
        else
            pop <= !holding && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        rsp_t want;
        if (rst_n && pop && !empty) begin
            if (due_results.size() == 0) begin
                note_fault("unexpected item", '0, rsp);
            end else begin
                want = due_results.pop_front();
                if (rsp.kind !== want.kind || rsp.data_byte !== want.data_byte
                    || rsp.status !== want.status || rsp.frame_address !== want.frame_address
                    || rsp.payload_length !== want.payload_length)
                    note_fault("mismatch", want, rsp);
            end
        end
    end

    initial begin
        holding = 1'b0;
        wait (hold_go);
        @(posedge clk);
        holding = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding = 1'b0;
    end

    initial begin
        #3_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic plan(input logic [1:0] op, input logic [7:0] b);
        cmd_plan.push_back(cmd_t'{opcode: op, rx_byte: b});
        planned++;
    endtask

    task automatic plan_ticks(input int n);
        repeat (n) plan(OP_TICK, 8'($urandom));
    endtask

    task automatic plan_frame_end();
        plan_ticks(gap_ticks + 1 + $urandom_range(0, guard_ticks));
        if ($urandom_range(3) == 0) begin
            plan(OP_BYTE, 8'($urandom));
            plan_ticks(guard_ticks);
        end
    endtask

    task automatic plan_frame(input int n_payload, input bit bad_crc);
        logic [7:0]  d;
        logic [15:0] c;
        plan(OP_ARM, 8'($urandom));
        if (resp_ticks <= 16 && $urandom_range(3) == 0)
            plan_ticks($urandom_range(0, resp_ticks - 1));
        d = 8'($urandom);
        c = crc16_modbus(16'hFFFF, d);
        plan(OP_BYTE, d);
        for (int i = 0; i < n_payload; i++) begin
            d = 8'($urandom);
            c = crc16_modbus(c, d);
            plan(OP_BYTE, d);
            if ($urandom_range(7) == 0)
                plan_ticks($urandom_range(0, gap_ticks));
        end
        if (bad_crc)
            c = c ^ (16'h1 << $urandom_range(15));
        plan(OP_BYTE, c[7:0]);
        plan(OP_BYTE, c[15:8]);
        plan_frame_end();
    endtask

    task automatic plan_mix(input int n_items);
        int target;
        int r;
        target = planned + n_items;
        while (planned < target) begin
            r = $urandom_range(99);
            if (r < 60) begin
                plan_frame($urandom_range(0, 10), $urandom_range(7) == 0);
            end else if (r < 70) begin
                plan(OP_ARM, 8'($urandom));
                repeat ($urandom_range(1, 3)) plan(OP_BYTE, 8'($urandom));
                plan_frame_end();
            end else if (r < 78) begin
                plan(OP_ARM, 8'($urandom));
                plan_ticks(resp_ticks + $urandom_range(0, 2));
            end else if (r < 86) begin
                plan(OP_ARM, 8'($urandom));
                repeat ($urandom_range(1, 5)) plan(OP_BYTE, 8'($urandom));
            end else begin
                repeat ($urandom_range(1, 4)) plan(2'($urandom_range(3)), 8'($urandom));
            end
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_FRAME_GAP: gap_ticks   = val[19:0];
            REG_GUARD:     guard_ticks = val[19:0];
            REG_TIMEOUT:   resp_ticks  = val;
            default: ;
        endcase
    endtask

    task automatic load_regs(input int gap, input int grd, input int tmo);
        write_reg(REG_FRAME_GAP, 24'(gap));
        write_reg(REG_GUARD, 24'(grd));
        write_reg(REG_TIMEOUT, 24'(tmo));
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_random_regs();
        load_regs($urandom_range(1, 4), $urandom_range(1, 10), $urandom_range(1, 10));
    endtask

    task automatic drain();
        while (cmd_plan.size() != 0 || due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    initial begin
        logic [15:0] c;
        gap_ticks      = FRAME_GAP_RST;
        guard_ticks    = GUARD_RST;
        resp_ticks     = TIMEOUT_RST;
        ph             = PH_IDLE;
        clear_frame();
        planned        = 0;
        fault_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_go        = 1'b0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_regs(2, 4, 3);
        plan(OP_TICK, 8'h00);
        plan(OP_NOP, 8'hFF);
        plan(OP_BYTE, 8'hFF);
        plan(OP_ARM, 8'h00);
        plan_ticks(3);
        plan(OP_ARM, 8'hFF);
        plan(OP_BYTE, 8'h00);
        plan(OP_BYTE, 8'hFF);
        plan_ticks(3);
        plan(OP_BYTE, 8'h5A);
        plan_ticks(1);
        c = crc16_modbus(16'hFFFF, 8'hFF);
        c = crc16_modbus(c, 8'h00);
        c = crc16_modbus(c, 8'hFF);
        plan(OP_ARM, 8'h00);
        plan(OP_BYTE, 8'hFF);
        plan(OP_BYTE, 8'h00);
        plan(OP_BYTE, 8'hFF);
        plan(OP_BYTE, c[7:0]);
        plan(OP_BYTE, c[15:8]);
        plan_ticks(3);
        drain();

        load_regs(3, 6, 5);
        hold_go = 1'b1;
        plan_frame(300, 1'b0);
        plan_mix(40);
        drain();

        load_regs(20'hFFFFF, 20'hFFFFF, 24'hFFFFFF);
        plan(OP_ARM, 8'($urandom));
        plan_ticks(5);
        repeat (7) plan(OP_BYTE, 8'($urandom));
        plan_ticks(10);
        drain();

        load_regs(1, 1, 1);
        plan_mix(60);
        drain();

        for (int p = 1; p < 4; p++) begin
            send_idle_pct  = (p == 1) ? 84 : (p == 3) ? 11 : 0;
            recv_stall_pct = (p == 2) ? 84 : (p == 3) ? 11 : 0;
            repeat (2) begin
                load_random_regs();
                plan_mix(50);
                drain();
            end
        end

        repeat (20) @(posedge clk);
        if (fault_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/mrtu_pkg.sv
rtl/mrtu_fifo.sv
rtl/mrtu_front.sv
rtl/mrtu_back.sv
rtl/modbus_rtu_frame_receiver_core.sv
bench/modbus_rtu_frame_receiver_core_tb.sv
